### design/rfb_pkg.sv
`timescale 1ns / 1ps

package rfb_pkg;

  localparam int unsigned FRAME_WIDTH  = 320;
  localparam int unsigned FRAME_HEIGHT = 170;

  localparam int unsigned PIXELS     = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(PIXELS);
  localparam int unsigned HDR_BYTES  = 54;
  localparam int unsigned HDR_IDX_W  = $clog2(HDR_BYTES);
  localparam int unsigned ROW_BYTES  = FRAME_WIDTH * 3;
  localparam int unsigned DATA_BYTES = ROW_BYTES * FRAME_HEIGHT;
  localparam int unsigned FILE_BYTES = HDR_BYTES + DATA_BYTES;
  localparam int unsigned INFO_BYTES = 40;
  localparam int unsigned BITS_PER_PX = 24;
  localparam int unsigned PX_PER_METER = 2835;
  localparam int unsigned PLANES     = 1;
  localparam logic [7:0] MAGIC_B     = 8'h42;
  localparam logic [7:0] MAGIC_M     = 8'h4D;

  localparam int unsigned B5_MAX    = 31;
  localparam int unsigned G6_MAX    = 63;
  localparam int unsigned COLOR_MAX = 255;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned OFF_W  = 18;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 8;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Exact division by a constant through a reciprocal for values below 2**OFF_W.
  localparam int unsigned SH3 = OFF_W + 2;
  localparam int unsigned SHW = OFF_W + $clog2(FRAME_WIDTH);
  localparam longint unsigned RECIP3_L = ((64'd1 << SH3) + 64'd2) / 64'd3;
  localparam longint unsigned RECIPW_L =
    ((64'd1 << SHW) + 64'(FRAME_WIDTH) - 64'd1) / 64'(FRAME_WIDTH);
  localparam logic [OFF_W:0] RECIP3_C = RECIP3_L[OFF_W:0];
  localparam logic [OFF_W:0] RECIPW_C = RECIPW_L[OFF_W:0];
  localparam logic [31:0] LAST_ROW_BASE = 32'((FRAME_HEIGHT - 1) * FRAME_WIDTH);

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ_HDR,
    CMD_READ_PIX,
    CMD_READ_OUT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [ADDR_W-1:0]     addr;
    logic [PIX_W-1:0]      wdata;
    logic [HDR_IDX_W-1:0]  hdr_idx;
    logic [1:0]            comp;
  } cmd_t;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_tab_t;
  typedef logic [31:0][7:0] scale5_tab_t;
  typedef logic [63:0][7:0] scale6_tab_t;

  function automatic hdr_tab_t build_hdr();
    hdr_tab_t t;
    logic [31:0] file_sz, data_off, info_sz, wid, hgt, img_sz, ppm;
    t        = '0;
    file_sz  = 32'(FILE_BYTES);
    data_off = 32'(HDR_BYTES);
    info_sz  = 32'(INFO_BYTES);
    wid      = 32'(FRAME_WIDTH);
    hgt      = 32'(FRAME_HEIGHT);
    img_sz   = 32'(DATA_BYTES);
    ppm      = 32'(PX_PER_METER);
    t[0] = MAGIC_B;
    t[1] = MAGIC_M;
    for (int k = 0; k < 4; k++) begin
      t[2 + k]  = file_sz[8*k +: 8];
      t[10 + k] = data_off[8*k +: 8];
      t[14 + k] = info_sz[8*k +: 8];
      t[18 + k] = wid[8*k +: 8];
      t[22 + k] = hgt[8*k +: 8];
      t[34 + k] = img_sz[8*k +: 8];
      t[38 + k] = ppm[8*k +: 8];
      t[42 + k] = ppm[8*k +: 8];
    end
    t[26] = 8'(PLANES);
    t[28] = 8'(BITS_PER_PX);
    return t;
  endfunction

  function automatic scale5_tab_t build_scale5();
    scale5_tab_t t;
    for (int c = 0; c < 32; c++) begin
      t[c] = 8'((c * COLOR_MAX) / B5_MAX);
    end
    return t;
  endfunction

  function automatic scale6_tab_t build_scale6();
    scale6_tab_t t;
    for (int c = 0; c < 64; c++) begin
      t[c] = 8'((c * COLOR_MAX) / G6_MAX);
    end
    return t;
  endfunction

  localparam hdr_tab_t    HDR_TAB    = build_hdr();
  localparam scale5_tab_t SCALE5_TAB = build_scale5();
  localparam scale6_tab_t SCALE6_TAB = build_scale6();

endpackage

### design/rgb565_frame_to_bmp24_reader.sv
`timescale 1ns / 1ps

// Frame store of 320 x 170 byte-swapped RGB565 pixels, read out as a 24-bit BMP file one
// byte per transfer. A store transfer (tuser low) writes one pixel and returns nothing; a read
// transfer (tuser high) returns the file byte at its offset, with tuser high when the offset
// lies inside the file. While the output is not stalled, the block takes one transfer per
// clock and delivers one byte per clock: a four-stage address pipeline works out the row,
// column and color of each offset and feeds a four-entry queue, and the back end makes one
// frame memory access per cycle through its single write and single read port. A read
// result passes the address stages, the queue, a command register and an output register.
// The memory has no reset and no clearing pass; a pixel must be stored before it is read.
module rgb565_frame_to_bmp24_reader import rfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // pixel_index [15:0], pixel_value [31:16], byte_offset [49:32], zeros above
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // operation [0]
  input  logic [0:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // file_byte [7:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // in_range [0]
  output logic [0:0]           m_axis_tuser_o
);

  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  rfb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_o          (push),
    .push_cmd_o      (push_cmd),
    .full_i          (full)
  );

  rfb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  rfb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

### design/rfb_ram.sv
`timescale 1ns / 1ps

module rfb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/rfb_queue.sv
`timescale 1ns / 1ps

module rfb_queue import rfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign full_o    = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### design/rfb_front.sv
`timescale 1ns / 1ps

module rfb_front import rfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [0:0]           s_axis_tuser_i,
  output logic                 push_o,
  output cmd_t                 push_cmd_o,
  input  logic                 full_i
);

  typedef struct packed {
    cmd_t             cmd;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] p;
    logic [OFF_W-1:0] row;
  } stage_t;

  stage_t s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  logic   v1_q, v1_d, v2_q, v3_q, v4_q;
  logic   en, accept;

  logic [PIX_W-1:0]   pixel_index;
  logic [PIX_W-1:0]   pixel_value;
  logic [OFF_W-1:0]   byte_offset;
  logic [2*OFF_W:0]   prod3, prodw;
  logic [OFF_W-1:0]   rem;
  logic [31:0]        idx_full;

  assign pixel_index = s_axis_tdata_i[15:0];
  assign pixel_value = s_axis_tdata_i[31:16];
  assign byte_offset = s_axis_tdata_i[49:32];

  assign en              = !v4_q || !full_i;
  assign accept          = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;
  assign push_o          = v4_q && !full_i;
  assign push_cmd_o      = s4_q.cmd;

  always_comb begin
    s1_d             = '0;
    s1_d.cmd.addr    = ADDR_W'(pixel_index);
    s1_d.cmd.wdata   = pixel_value;
    s1_d.cmd.hdr_idx = byte_offset[HDR_IDX_W-1:0];
    s1_d.off         = OFF_W'(byte_offset - OFF_W'(HDR_BYTES));
    v1_d             = accept;
    if (s_axis_tuser_i[0] == OP_STORE) begin
      s1_d.cmd.kind = CMD_WRITE;
      if (32'(pixel_index) >= 32'(PIXELS)) begin
        v1_d = 1'b0;
      end
    end else if (32'(byte_offset) >= 32'(FILE_BYTES)) begin
      s1_d.cmd.kind = CMD_READ_OUT;
    end else if (32'(byte_offset) < 32'(HDR_BYTES)) begin
      s1_d.cmd.kind = CMD_READ_HDR;
    end else begin
      s1_d.cmd.kind = CMD_READ_PIX;
    end
  end

  // Pixel number within the data area: offset divided by three.
  always_comb begin
    prod3  = (2*OFF_W+1)'(s1_q.off) * (2*OFF_W+1)'(RECIP3_C);
    s2_d   = s1_q;
    s2_d.p = OFF_W'(prod3 >> SH3);
  end

  // Row counted from the bottom and the color component of the byte.
  always_comb begin
    prodw         = (2*OFF_W+1)'(s2_q.p) * (2*OFF_W+1)'(RECIPW_C);
    rem           = s2_q.off - (s2_q.p << 1) - s2_q.p;
    s3_d          = s2_q;
    s3_d.row      = OFF_W'(prodw >> SHW);
    s3_d.cmd.comp = rem[1:0];
  end

  // Top-down store address of the pixel in that row.
  always_comb begin
    idx_full = LAST_ROW_BASE + 32'(s3_q.p)
             - ((32'(s3_q.row) * 32'(FRAME_WIDTH)) << 1);
    s4_d     = s3_q;
    if (s3_q.cmd.kind == CMD_READ_PIX) begin
      s4_d.cmd.addr = ADDR_W'(idx_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= v1_d;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

endmodule

### design/rfb_back.sv
`timescale 1ns / 1ps

module rfb_back import rfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [0:0]           m_axis_tuser_o
);

  cmd_t             b1_q, b1_d;
  logic             b1_valid_q, b1_valid_d;
  logic             o_valid_q, o_valid_d;
  logic [7:0]       o_byte_q, o_byte_d;
  logic             o_range_q, o_range_d;
  logic             o_adv, b1_adv;
  logic             ram_we, ram_re;
  logic [PIX_W-1:0] rdata;
  logic [PIX_W-1:0] swapped;
  logic [4:0]       r5, b5;
  logic [5:0]       g6;

  assign o_adv  = !o_valid_q || m_axis_tready_i;
  assign b1_adv = !b1_valid_q || o_adv;
  assign pop_o  = !empty_i && b1_adv;
  assign ram_we = pop_o && (cmd_i.kind == CMD_WRITE);
  assign ram_re = pop_o && (cmd_i.kind == CMD_READ_PIX);

  rfb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIXELS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.wdata),
    .re_i    (ram_re),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    b1_valid_d = b1_valid_q;
    b1_d       = b1_q;
    if (b1_adv) begin
      b1_valid_d = pop_o && (cmd_i.kind != CMD_WRITE);
      b1_d       = cmd_i;
    end
  end

  // The stored word is byte-swapped RGB565.
  always_comb begin
    swapped   = {rdata[7:0], rdata[15:8]};
    r5        = swapped[15:11];
    g6        = swapped[10:5];
    b5        = swapped[4:0];
    o_valid_d = o_valid_q;
    o_byte_d  = o_byte_q;
    o_range_d = o_range_q;
    if (o_adv) begin
      o_valid_d = b1_valid_q;
      o_range_d = 1'b1;
      unique case (b1_q.kind)
        CMD_READ_HDR: o_byte_d = HDR_TAB[b1_q.hdr_idx];
        CMD_READ_PIX: begin
          unique case (b1_q.comp)
            2'd0:    o_byte_d = SCALE5_TAB[b5];
            2'd1:    o_byte_d = SCALE6_TAB[g6];
            default: o_byte_d = SCALE5_TAB[r5];
          endcase
        end
        default: begin
          o_byte_d  = '0;
          o_range_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      b1_valid_q <= b1_valid_d;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q      <= b1_d;
    o_byte_q  <= o_byte_d;
    o_range_q <= o_range_d;
  end

  assign m_axis_tvalid_o   = o_valid_q;
  assign m_axis_tdata_o    = o_byte_q;
  assign m_axis_tuser_o[0] = o_range_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rfb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 925;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned N_DIRECTED   = 25;

  localparam int unsigned COMP_B = 0;
  localparam int unsigned COMP_G = 1;
  localparam int unsigned COMP_R = 2;

  typedef struct packed {
    logic [7:0] value;
    logic       in_range;
  } bmp_out_t;

  typedef struct {
    logic        op;
    logic [15:0] idx;
    logic [15:0] val;
    logic [17:0] off;
    bit          typed;
    logic [7:0]  byte_exp;
    logic        in_exp;
  } stim_row_t;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [0:0]           s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;

  logic [15:0]  frame_copy [PIXELS];
  bit           px_written [PIXELS];
  int unsigned  written_px [$];
  bmp_out_t     expected_bytes [$];
  bmp_out_t     want_byte;

  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;
  int unsigned  rx_stall = 0;
  bit           rx_calm = 1'b0;
  bit           rx_long_hold = 1'b0;
  bit           tx_burst = 1'b0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_READ,  16'd0, 16'd0, 18'd0,  1'b1, 8'h42,  1'b1},
    '{OP_READ,  16'd0, 16'd0, 18'd1,  1'b1, 8'h4D,  1'b1},
    '{OP_READ,  16'd0, 16'd0, 18'd10, 1'b1, 8'd54,  1'b1},
    '{OP_READ,  16'd0, 16'd0, 18'd14, 1'b1, 8'd40,  1'b1},
    '{OP_READ,  16'd0, 16'd0, 18'd26, 1'b1, 8'd1,   1'b1},
    '{OP_READ,  16'd0, 16'd0, 18'd28, 1'b1, 8'd24,  1'b1},
    '{OP_READ,  16'd0, 16'd0, 18'd2,  1'b0, 8'd0,   1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'd18, 1'b0, 8'd0,   1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'd22, 1'b0, 8'd0,   1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'd38, 1'b0, 8'd0,   1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'd53, 1'b1, 8'd0,   1'b1},
    '{OP_READ,  16'd0, 16'd0, 18'(FILE_BYTES), 1'b1, 8'd0, 1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'h3FFFF, 1'b1, 8'd0, 1'b0},
    '{OP_STORE, 16'd0, 16'hFFFF, 18'd0, 1'b0, 8'd0, 1'b0},
    '{OP_STORE, 16'(PIXELS - 1), 16'h0000, 18'd0, 1'b0, 8'd0, 1'b0},
    '{OP_STORE, 16'((FRAME_HEIGHT - 1) * FRAME_WIDTH), 16'h00F8, 18'd0, 1'b0, 8'd0, 1'b0},
    '{OP_STORE, 16'(FRAME_WIDTH - 1), 16'h1F00, 18'd0, 1'b0, 8'd0, 1'b0},
    '{OP_STORE, 16'(PIXELS), 16'hFFFF, 18'd0, 1'b0, 8'd0, 1'b0},
    '{OP_STORE, 16'hFFFF, 16'h5AA5, 18'd0, 1'b0, 8'd0, 1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'(HDR_BYTES), 1'b0, 8'd0, 1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'(HDR_BYTES + 2), 1'b0, 8'd0, 1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'(FILE_BYTES - 3), 1'b0, 8'd0, 1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'(FILE_BYTES - 1), 1'b0, 8'd0, 1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'(HDR_BYTES + (FRAME_HEIGHT - 1) * ROW_BYTES + 1),
      1'b0, 8'd0, 1'b0},
    '{OP_READ,  16'd0, 16'd0, 18'(HDR_BYTES + ROW_BYTES - 2), 1'b0, 8'd0, 1'b0}
  };

  rgb565_frame_to_bmp24_reader dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] header_byte(int unsigned pos);
    logic [31:0] word;
    int unsigned base;
    word = '0;
    base = 0;
    if (pos == 0) return 8'h42;
    if (pos == 1) return 8'h4D;
    if (pos == 26) return 8'd1;
    if (pos == 28) return 8'd24;
    if (pos >= 2 && pos < 6) begin
      word = FILE_BYTES;
      base = 2;
    end else if (pos >= 10 && pos < 14) begin
      word = 54;
      base = 10;
    end else if (pos >= 14 && pos < 18) begin
      word = 40;
      base = 14;
    end else if (pos >= 18 && pos < 22) begin
      word = FRAME_WIDTH;
      base = 18;
    end else if (pos >= 22 && pos < 26) begin
      word = FRAME_HEIGHT;
      base = 22;
    end else if (pos >= 34 && pos < 38) begin
      word = DATA_BYTES;
      base = 34;
    end else if (pos >= 38 && pos < 46) begin
      word = 2835;
      base = (pos < 42) ? 38 : 42;
    end else begin
      return 8'd0;
    end
    return word[8 * (pos - base) +: 8];
  endfunction

  function automatic bmp_out_t bmp_byte(int unsigned off);
    bmp_out_t    res;
    int unsigned rel, row, rem, x, comp, y;
    logic [15:0] raw, rgb;
    res = '0;
    if (off >= FILE_BYTES) return res;
    res.in_range = 1'b1;
    if (off < HDR_BYTES) begin
      res.value = header_byte(off);
      return res;
    end
    rel  = off - HDR_BYTES;
    row  = rel / ROW_BYTES;
    rem  = rel % ROW_BYTES;
    x    = rem / 3;
    comp = rem % 3;
    y    = FRAME_HEIGHT - 1 - row;
    raw  = frame_copy[y * FRAME_WIDTH + x];
    rgb  = {raw[7:0], raw[15:8]};
    case (comp)
      COMP_B:  res.value = 8'((32'(rgb[4:0]) * 255) / 31);
      COMP_G:  res.value = 8'((32'(rgb[10:5]) * 255) / 63);
      default: res.value = 8'((32'(rgb[15:11]) * 255) / 31);
    endcase
    return res;
  endfunction

  function automatic int unsigned pixel_offset(int unsigned idx, int unsigned comp);
    return HDR_BYTES + (FRAME_HEIGHT - 1 - idx / FRAME_WIDTH) * ROW_BYTES
           + (idx % FRAME_WIDTH) * 3 + comp;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_item(input logic op, input logic [15:0] idx, input logic [15:0] val,
                           input logic [17:0] off, input bit typed, input bmp_out_t typed_exp);
    int unsigned gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, off, val, idx};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_tready);
    if (op == OP_STORE) begin
      if (idx < PIXELS) begin
        frame_copy[idx] = val;
        if (!px_written[idx]) begin
          px_written[idx] = 1'b1;
          written_px.push_back(idx);
        end
      end
    end else begin
      expected_bytes.push_back(typed ? typed_exp : bmp_byte(off));
    end
  endtask

  task automatic read_pixel(input int unsigned idx, input int unsigned comp);
    send_item(OP_READ, 16'd0, 16'd0, 18'(pixel_offset(idx, comp)), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual byte %02h in_range %0d",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (m_tdata !== want_byte.value) begin
          $display("%0t: file byte mismatch, expected %02h, actual %02h",
                   $time, want_byte.value, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want_byte.in_range) begin
          $display("%0t: in_range mismatch, expected %0d, actual %0d",
                   $time, want_byte.in_range, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        rx_stall = LONG_HOLD;
      end
      if ($urandom_range(199) == 0) rx_calm = !rx_calm;
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_calm) rx_stall = idle_len();
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned r;
    int unsigned idx;
    int unsigned comp;
    bmp_out_t    typed_exp;
    logic [15:0] val;
    bit          hold_done;
    bit          pause_done;

    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_exp = {directed_rows[i].byte_exp, directed_rows[i].in_exp};
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].off, directed_rows[i].typed, typed_exp);
    end

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) == 0) tx_burst = !tx_burst;

      // The receiver holds off while reads keep coming, so the block backs up.
      if (!hold_done && sent >= 300) begin
        hold_done = 1'b1;
        rx_long_hold = 1'b1;
        tx_burst = 1'b1;
        for (int k = 0; k < 60; k++) begin
          read_pixel(written_px[$urandom_range(written_px.size() - 1)], $urandom_range(COMP_R));
        end
        tx_burst = 1'b0;
        sent += 60;
      end

      if (!pause_done && sent >= 600) begin
        pause_done = 1'b1;
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk_i);
      end

      r = $urandom_range(99);
      if (r < 30) begin
        if (written_px.size() > 0 && $urandom_range(3) == 0) begin
          idx = written_px[$urandom_range(written_px.size() - 1)];
        end else begin
          idx = $urandom_range(PIXELS - 1);
        end
        send_item(OP_STORE, 16'(idx), 16'($urandom), 18'($urandom), 1'b0, '0);
        sent++;
      end else if (r < 34) begin
        send_item(OP_STORE, 16'($urandom_range(16'hFFFF, PIXELS)), 16'($urandom),
                  18'($urandom), 1'b0, '0);
        sent++;
      end else if (r < 44) begin
        idx = $urandom_range(PIXELS - 1);
        val = 16'($urandom);
        send_item(OP_STORE, 16'(idx), val, 18'($urandom), 1'b0, '0);
        read_pixel(idx, $urandom_range(COMP_R));
        sent += 2;
      end else if (r < 74) begin
        read_pixel(written_px[$urandom_range(written_px.size() - 1)], $urandom_range(COMP_R));
        sent++;
      end else if (r < 84) begin
        send_item(OP_READ, 16'($urandom), 16'($urandom), 18'($urandom_range(HDR_BYTES - 1)),
                  1'b0, '0);
        sent++;
      end else if (r < 92) begin
        send_item(OP_READ, 16'($urandom), 16'($urandom),
                  18'($urandom_range(18'h3FFFF, FILE_BYTES)), 1'b0, '0);
        sent++;
      end else begin
        idx = written_px[$urandom_range(written_px.size() - 1)];
        for (comp = COMP_B; comp <= COMP_R; comp++) read_pixel(idx, comp);
        sent += 3;
      end
    end
    s_tvalid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
